[design/rmst_pkg.sv]
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared constants and types for the range maximum segment tree core.
// ----------------------------------------------------------------------------
`default_nettype none

package rmst_pkg;

  // Number of value slots (leaves) in the tree
  localparam int LEAVES  = 1024;
  localparam int LEAF_AW = $clog2(LEAVES);
  // Node index into the tree memory: nodes 0 .. 2*LEAVES-1
  localparam int NODE_AW = LEAF_AW + 1;
  localparam int NODES   = 2 * LEAVES;
  // Query cursor width, wide enough to hold 2*LEAVES
  localparam int CUR_W   = NODE_AW + 1;

  // Field widths of the interface
  localparam int VAL_W   = 32;
  localparam int POS_W   = 10;
  localparam int RANGE_W = 11;

  // Command codes
  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Tree memory access for one cycle
  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    logic [VAL_W-1:0]   wdata;
    logic               re;
    logic [NODE_AW-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

[design/rmst_node_ram.sv]
// ----------------------------------------------------------------------------
// rmst_node_ram
// Tree node store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_node_ram (
  input  wire logic                           clk,
  input  wire rmst_pkg::ram_req_t             req,
  output logic [rmst_pkg::VAL_W-1:0]          rd_data
);
  import rmst_pkg::*;

  logic [VAL_W-1:0] mem [NODES];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

[design/range_max_segment_tree_core.sv]
// ----------------------------------------------------------------------------
// range_max_segment_tree_core
// Range maximum segment tree over unsigned slots, point set and range query.
// ----------------------------------------------------------------------------
// After reset the core clears its 2048-entry node memory, one node a cycle,
// and holds in_ready low until the clearing pass ends. It then handles one
// command at a time, all work going through the single node memory (one read
// and one write a cycle, registered read data). A set uses the accepting
// cycle to issue the leaf read, then refreshes the tree level by level up to
// the root, checking each node and fetching its sibling, and stops early
// when the refresh finds a node already correct. A query walks both range
// edges up the tree and ends with a closing bounds check; an empty range
// finishes at once. The finishing state loads the result register once the
// previous result has been taken, which frees the core for the next command
// while the result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module range_max_segment_tree_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          command,
  input  wire logic [rmst_pkg::POS_W-1:0]    position,
  input  wire logic [rmst_pkg::VAL_W-1:0]    new_value,
  input  wire logic [rmst_pkg::RANGE_W-1:0]  range_lo,
  input  wire logic [rmst_pkg::RANGE_W-1:0]  range_hi,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rmst_pkg::VAL_W-1:0]         max_value
);
  import rmst_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UCHECK,
    ST_USIB,
    ST_QUERY,
    ST_DONE
  } state_t;

  localparam logic [RANGE_W-1:0] LEAVES_R = RANGE_W'(LEAVES);
  localparam logic [CUR_W-1:0]   LEAVES_C = CUR_W'(LEAVES);
  localparam logic [NODE_AW-1:0] LEAVES_N = NODE_AW'(LEAVES);
  localparam logic [NODE_AW-1:0] ROOT     = NODE_AW'(1);

  state_t             state, state_next;
  logic [NODE_AW-1:0] clr_addr, clr_addr_next;
  logic [NODE_AW-1:0] node, node_next;
  logic [VAL_W-1:0]   val, val_next;
  logic [CUR_W-1:0]   cur_l, cur_l_next;
  logic [CUR_W-1:0]   cur_r, cur_r_next;
  logic [VAL_W-1:0]   res, res_next;
  logic               pend, pend_next;
  logic               out_valid_next;
  logic [VAL_W-1:0]   max_value_next;

  ram_req_t           ram_req;
  logic [VAL_W-1:0]   rd_data;

  logic [RANGE_W-1:0] lo_sat, hi_sat;
  logic [CUR_W-1:0]   r_dec;
  logic [VAL_W-1:0]   res_fold;
  logic               pos_ok;

  rmst_node_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // query bounds saturate at the slot count
  assign lo_sat = (range_lo > LEAVES_R) ? LEAVES_R : range_lo;
  assign hi_sat = (range_hi > LEAVES_R) ? LEAVES_R : range_hi;
  assign pos_ok = (32'(position) < LEAVES);

  assign r_dec    = cur_r - CUR_W'(1);
  assign res_fold = (pend && (rd_data > res)) ? rd_data : res;
  assign in_ready = (state == ST_IDLE);

  // sequencer next state and memory requests
  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    node_next      = node;
    val_next       = val;
    cur_l_next     = cur_l;
    cur_r_next     = cur_r;
    res_next       = res;
    pend_next      = pend;
    out_valid_next = out_valid;
    max_value_next = max_value;
    ram_req        = '0;

    // result taken downstream
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        ram_req.wdata = '0;
        clr_addr_next = clr_addr + NODE_AW'(1);
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          res_next  = '0;
          pend_next = 1'b0;
          if (command == CMD_QUERY) begin
            cur_l_next = CUR_W'(lo_sat) + LEAVES_C;
            cur_r_next = CUR_W'(hi_sat) + LEAVES_C;
            state_next = ST_QUERY;
          end else if (pos_ok) begin
            node_next     = LEAVES_N | NODE_AW'(position);
            val_next      = new_value;
            ram_req.re    = 1'b1;
            ram_req.raddr = LEAVES_N | NODE_AW'(position);
            state_next    = ST_UCHECK;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      // rd_data holds the current node; fetch its sibling meanwhile
      ST_UCHECK: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = node ^ ROOT;
        if (rd_data == val) begin
          state_next = ST_DONE;
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = node;
          ram_req.wdata = val;
          if (node == ROOT) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_USIB;
          end
        end
      end
      // rd_data holds the sibling; move up and fetch the parent
      ST_USIB: begin
        val_next      = (rd_data > val) ? rd_data : val;
        node_next     = node >> 1;
        ram_req.re    = 1'b1;
        ram_req.raddr = node >> 1;
        state_next    = ST_UCHECK;
      end
      // bottom-up range walk: read one edge node, or move both edges up a level
      ST_QUERY: begin
        res_next  = res_fold;
        pend_next = 1'b0;
        if (cur_l >= cur_r) begin
          state_next = ST_DONE;
        end else if (cur_l[0]) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = cur_l[NODE_AW-1:0];
          cur_l_next    = cur_l + CUR_W'(1);
          pend_next     = 1'b1;
        end else if (cur_r[0]) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = r_dec[NODE_AW-1:0];
          cur_r_next    = r_dec;
          pend_next     = 1'b1;
        end else begin
          cur_l_next = cur_l >> 1;
          cur_r_next = cur_r >> 1;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          max_value_next = res;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
    node      <= node_next;
    val       <= val_next;
    cur_l     <= cur_l_next;
    cur_r     <= cur_r_next;
    res       <= res_next;
    max_value <= max_value_next;
  end

`ifndef SYNTHESIS
  // no command is taken straight after reset, when the clearing pass begins
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("command accepted during clearing pass");

  // node 0 is never written outside the clearing pass
  a_no_node0_write: assert property (@(posedge clk) disable iff (rst)
    (ram_req.we && state != ST_CLEAR) |-> (ram_req.waddr != '0))
    else $error("write to unused node 0");

  // pending read data is only folded inside a query walk
  a_pend_in_query: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == ST_QUERY))
    else $error("read data pending outside a query");

  // refresh path never reaches node 0
  a_node_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UCHECK || state == ST_USIB) |-> (node != '0))
    else $error("update walked past the root");

  // a finished command loads the result register on the next edge when free
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_valid) |=> out_valid)
    else $error("result not loaded");
`endif

endmodule

`default_nettype wire
